FILE: rtl/core/rsp929_pkg.sv
// Shared types, codes and field constants of the GF(929) parity generator.
package rsp929_pkg;

  // Field and word geometry
  localparam int unsigned WordW      = 10;
  localparam int unsigned LevelW     = 5;
  localparam int unsigned ProdW      = 2 * WordW;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipW     = 21;
  localparam logic [WordW-1:0] FieldP = 10'd929;

  // floor(2^30 / 929): quotient estimate is exact or one low for any product
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'((64'd1 << RecipShift) / 64'd929);

  // First root is -3; each generator round multiplies it by 3
  localparam logic [WordW-1:0] RootInit = FieldP - 10'd3;
  localparam logic [WordW-1:0] RootMul  = 10'd3;

  // Command codes carried in tuser
  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdPush  = 2'd1,
    CmdPull  = 2'd2
  } cmd_e;

  // What a multiply-accumulate result is for
  typedef enum logic [1:0] {
    KindGen  = 2'd0,
    KindPush = 2'd1,
    KindRoot = 2'd2
  } mac_kind_e;

  typedef struct packed {
    mac_kind_e kind;
    logic      sub;
  } mac_tag_t;

  typedef struct packed {
    logic [WordW-1:0] parity_word;
    logic             last;
  } result_t;

  typedef struct packed {
    logic idle;
    logic mac_busy;
  } seq_stat_t;

endpackage

FILE: rtl/core/rsp929_mac.sv
// Pipelined modular multiply-accumulate unit: res = (c +/- a*b) mod 929.
module rsp929_mac import rsp929_pkg::*; #(
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  input  logic [WordW-1:0] c_i,
  input  mac_tag_t         tag_i,
  input  logic [AddrW-1:0] addr_i,
  output logic             out_valid_o,
  output logic [WordW-1:0] res_o,
  output mac_tag_t         tag_o,
  output logic [AddrW-1:0] addr_o,
  output logic             busy_o
);

  localparam int unsigned EstW = ProdW + RecipW;

  logic             v1_q, v2_q, v3_q, v4_q;
  logic [ProdW-1:0] p1_q, p2_q;
  logic [WordW-1:0] q2_q, r3_q, res4_q;
  logic [WordW-1:0] c1_q, c2_q, c3_q;
  mac_tag_t         t1_q, t2_q, t3_q, t4_q;
  logic [AddrW-1:0] a1_q, a2_q, a3_q, a4_q;

  logic [EstW-1:0]  est;
  logic [ProdW-1:0] qp, r0;
  logic [WordW-1:0] r3_d;
  logic [WordW:0]   sum;
  logic [WordW-1:0] res_d;

  // Quotient estimate by reciprocal multiplication
  assign est = EstW'(p1_q) * EstW'(RecipMul);

  // Remainder with one correction step
  always_comb begin
    qp   = ProdW'(q2_q) * ProdW'(FieldP);
    r0   = p2_q - qp;
    r3_d = (r0 >= ProdW'(FieldP)) ? WordW'(r0 - ProdW'(FieldP)) : WordW'(r0);
  end

  // Accumulate into c with wrap into the field
  always_comb begin
    sum = {1'b0, c3_q} + {1'b0, r3_q};
    if (t3_q.sub) begin
      res_d = (c3_q >= r3_q) ? (c3_q - r3_q) : (c3_q + (FieldP - r3_q));
    end else begin
      res_d = (sum >= {1'b0, FieldP}) ? WordW'(sum - {1'b0, FieldP}) : WordW'(sum);
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    p1_q   <= ProdW'(a_i) * ProdW'(b_i);
    c1_q   <= c_i;
    t1_q   <= tag_i;
    a1_q   <= addr_i;
    q2_q   <= WordW'(est >> RecipShift);
    p2_q   <= p1_q;
    c2_q   <= c1_q;
    t2_q   <= t1_q;
    a2_q   <= a1_q;
    r3_q   <= r3_d;
    c3_q   <= c2_q;
    t3_q   <= t2_q;
    a3_q   <= a2_q;
    res4_q <= res_d;
    t4_q   <= t3_q;
    a4_q   <= a3_q;
  end

  assign out_valid_o = v4_q;
  assign res_o       = res4_q;
  assign tag_o       = t4_q;
  assign addr_o      = a4_q;
  assign busy_o      = v1_q | v2_q | v3_q | v4_q;

endmodule

FILE: rtl/core/rsp929_seq.sv
// Command sequencer with generator and remainder memories around the shared MAC.
module rsp929_seq import rsp929_pkg::*; #(
  parameter int unsigned MAX_PARITY = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  logic [1:0]        cmd_i,
  input  logic [WordW-1:0]  word_i,
  output logic              cmd_ready_o,
  input  logic [LevelW-1:0] level_i,
  output logic              res_valid_o,
  output result_t           res_o,
  input  logic              res_ready_i,
  output seq_stat_t         stat_o
);

  localparam int unsigned CntW  = $clog2(MAX_PARITY + 1);
  localparam int unsigned RemAw = $clog2(MAX_PARITY);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StClr      = 4'd1;
  localparam logic [3:0] StGenIss   = 4'd2;
  localparam logic [3:0] StGenRoot  = 4'd3;
  localparam logic [3:0] StGenDrain = 4'd4;
  localparam logic [3:0] StPushFb   = 4'd5;
  localparam logic [3:0] StPushIss  = 4'd6;
  localparam logic [3:0] StDrain    = 4'd7;
  localparam logic [3:0] StPullData = 4'd8;
  localparam logic [3:0] StPullOut  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CntW-1:0]  k_q, k_d, pidx_q, pidx_d, i_q, i_d, j_q, j_d;
  logic [WordW-1:0] fb_q, fb_d, dw_q, dw_d, root_q, g_hold_q;
  result_t          res_q, res_d;

  // Memories
  logic [WordW-1:0] gen_mem [MAX_PARITY+1];
  logic [WordW-1:0] rem_mem [MAX_PARITY];
  logic [WordW-1:0] g_rdata_q, rem_rdata_q;
  logic [CntW-1:0]  g_raddr;
  logic [RemAw-1:0] rem_raddr;
  logic             clr_we, init_we;

  // Read stage in front of the MAC
  logic             iss_v, iss_zero;
  mac_kind_e        iss_kind;
  logic [CntW-1:0]  iss_addr;
  logic             rd_v_q, rd_zero_q;
  mac_kind_e        rd_kind_q;
  logic [CntW-1:0]  rd_addr_q;

  // MAC connections
  logic [WordW-1:0] mac_a, mac_b, mac_c, mac_res;
  mac_tag_t         mac_tag, mac_tag_out;
  logic             mac_out_v, mac_busy;
  logic [CntW-1:0]  mac_addr;

  // Level decode and input word reduction
  logic [16:0]      k_wide;
  logic [CntW-1:0]  k_new;
  logic [WordW-1:0] word_mod;
  logic [WordW:0]   fb_sum;

  always_comb begin
    k_wide = 17'd1 << ({1'b0, level_i[3:0]} + 5'd1);
    if (level_i[LevelW-1]) begin
      k_new = '0;
    end else if (k_wide > 17'(MAX_PARITY)) begin
      k_new = CntW'(MAX_PARITY);
    end else begin
      k_new = CntW'(k_wide);
    end
    word_mod = (word_i >= FieldP) ? (word_i - FieldP) : word_i;
    fb_sum   = {1'b0, dw_q} + {1'b0, rem_rdata_q};
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    pidx_d    = pidx_q;
    i_d       = i_q;
    j_d       = j_q;
    fb_d      = fb_q;
    dw_d      = dw_q;
    res_d     = res_q;
    iss_v     = 1'b0;
    iss_kind  = KindGen;
    iss_zero  = 1'b0;
    iss_addr  = j_q;
    g_raddr   = '0;
    rem_raddr = '0;
    clr_we    = 1'b0;
    init_we   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          case (cmd_i)
            CmdStart: begin
              k_d     = k_new;
              pidx_d  = '0;
              j_d     = '0;
              init_we = 1'b1;
              if (k_new != '0) begin
                state_d = StClr;
              end
            end
            CmdPush: begin
              dw_d = word_mod;
              if (k_q != '0) begin
                state_d = StPushFb;
              end
            end
            CmdPull: begin
              if (pidx_q < k_q) begin
                rem_raddr = pidx_q[RemAw-1:0];
                state_d   = StPullData;
              end else begin
                res_d.parity_word = '0;
                res_d.last        = 1'b1;
                state_d           = StPullOut;
              end
            end
            default: ;
          endcase
        end
      end
      StClr: begin
        clr_we = 1'b1;
        if (j_q == k_q - CntOne) begin
          i_d     = CntOne;
          j_d     = CntOne;
          state_d = StGenIss;
        end else begin
          j_d = j_q + CntOne;
        end
      end
      StGenIss: begin
        g_raddr  = j_q - CntOne;
        iss_v    = 1'b1;
        iss_kind = KindGen;
        iss_zero = (j_q == i_q);
        if (j_q == CntOne) begin
          state_d = StGenRoot;
        end else begin
          j_d = j_q - CntOne;
        end
      end
      StGenRoot: begin
        iss_v    = 1'b1;
        iss_kind = KindRoot;
        state_d  = StGenDrain;
      end
      StGenDrain: begin
        if (!rd_v_q && !mac_busy) begin
          if (i_q == k_q) begin
            state_d = StIdle;
          end else begin
            i_d     = i_q + CntOne;
            j_d     = i_q + CntOne;
            state_d = StGenIss;
          end
        end
      end
      StPushFb: begin
        fb_d    = (fb_sum >= {1'b0, FieldP}) ? WordW'(fb_sum - {1'b0, FieldP})
                                              : WordW'(fb_sum);
        j_d     = '0;
        state_d = StPushIss;
      end
      StPushIss: begin
        g_raddr   = j_q + CntOne;
        rem_raddr = RemAw'(j_q + CntOne);
        iss_v     = 1'b1;
        iss_kind  = KindPush;
        iss_zero  = ((j_q + CntOne) == k_q);
        if (j_q == k_q - CntOne) begin
          state_d = StDrain;
        end else begin
          j_d = j_q + CntOne;
        end
      end
      StDrain: begin
        if (!rd_v_q && !mac_busy) begin
          state_d = StIdle;
        end
      end
      StPullData: begin
        res_d.parity_word = (rem_rdata_q == '0) ? '0 : (FieldP - rem_rdata_q);
        res_d.last        = ((pidx_q + CntOne) == k_q);
        pidx_d            = pidx_q + CntOne;
        state_d           = StPullOut;
      end
      StPullOut: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
      pidx_q  <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pidx_q  <= pidx_d;
      rd_v_q  <= iss_v;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    fb_q      <= fb_d;
    dw_q      <= dw_d;
    res_q     <= res_d;
    rd_kind_q <= iss_kind;
    rd_zero_q <= iss_zero;
    rd_addr_q <= iss_addr;
    if (rd_v_q && (rd_kind_q == KindGen)) begin
      g_hold_q <= g_rdata_q;
    end
    if (init_we) begin
      root_q <= RootInit;
    end else if (mac_out_v && (mac_tag_out.kind == KindRoot)) begin
      root_q <= mac_res;
    end
  end

  // Generator memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (init_we) begin
      gen_mem[0] <= WordW'(1);
    end else if (mac_out_v && (mac_tag_out.kind == KindGen)) begin
      gen_mem[mac_addr] <= mac_res;
    end
    g_rdata_q <= gen_mem[g_raddr];
  end

  // Remainder memory: clear sweep or MAC write, one registered read
  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      rem_mem[j_q[RemAw-1:0]] <= '0;
    end else if (mac_out_v && (mac_tag_out.kind == KindPush)) begin
      rem_mem[mac_addr[RemAw-1:0]] <= mac_res;
    end
    rem_rdata_q <= rem_mem[rem_raddr];
  end

  // Operand select for the MAC
  always_comb begin
    mac_a        = g_rdata_q;
    mac_b        = root_q;
    mac_c        = rd_zero_q ? '0 : g_hold_q;
    mac_tag.kind = rd_kind_q;
    mac_tag.sub  = 1'b0;
    case (rd_kind_q)
      KindPush: begin
        mac_a       = fb_q;
        mac_b       = g_rdata_q;
        mac_c       = rd_zero_q ? '0 : rem_rdata_q;
        mac_tag.sub = 1'b1;
      end
      KindRoot: begin
        mac_a = root_q;
        mac_b = RootMul;
        mac_c = '0;
      end
      default: ;
    endcase
  end

  rsp929_mac #(
    .AddrW(CntW)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rd_v_q),
    .a_i        (mac_a),
    .b_i        (mac_b),
    .c_i        (mac_c),
    .tag_i      (mac_tag),
    .addr_i     (rd_addr_q),
    .out_valid_o(mac_out_v),
    .res_o      (mac_res),
    .tag_o      (mac_tag_out),
    .addr_o     (mac_addr),
    .busy_o     (mac_busy)
  );

  assign cmd_ready_o     = (state_q == StIdle);
  assign res_valid_o     = (state_q == StPullOut);
  assign res_o           = res_q;
  assign stat_o.idle     = (state_q == StIdle);
  assign stat_o.mac_busy = mac_busy;

endmodule

FILE: rtl/core/reed_solomon_parity_gf929.sv
// Reed-Solomon parity generator over GF(929): stream ports, APB register, output register.
//
// Commands arrive on the s_axis channel, the command code in tuser and the data
// codeword in tdata. A start latches the parity count k = 2^(level+1) (none for a
// negative level, capped at MAX_PARITY), clears k remainder words and builds the
// generator with one shared modular multiply-accumulate unit, one coefficient per
// cycle plus a root update and a pipeline drain in each round. A push runs one
// division step over all k remainder taps through the same unit.
// A pull reads one remainder word and returns its negation on m_axis, tlast on
// the final word; a pull with nothing left returns 0 with tlast. A pull with a
// word left goes through a read state before its word is offered to the output
// register, a pull with none left skips the read state; the next command can be
// taken once the output register has taken the word.
// Starts, pushes and unused codes give no transaction on m_axis.
// s_axis_tready_o is low while a command is at work.
// The output register lets the next command be taken while a parity word waits;
// a second pull stalls until the receiver drains the first.
// security_level is written over APB at byte address 0 and used at the next start; the
// user must write it only while the block is idle, which the block does not enforce.
// Reset clears level, k and pull index; a start clears the remainder, used only below k.
module reed_solomon_parity_gf929 import rsp929_pkg::*; #(
  parameter int unsigned MAX_PARITY = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Command stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] data_word, [15:10] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  // Parity stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [9:0] parity_word, [15:10] zero
  output logic        m_axis_tlast_o
);

  logic [LevelW-1:0] level_q;
  logic              cfg_write;
  logic              seq_res_valid, out_ready, out_v_q;
  result_t           seq_res, out_q;
  seq_stat_t         seq_stat;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata    = paddr[2] ? '0 : {{(32 - LevelW){1'b0}}, level_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (cfg_write) begin
      level_q <= pwdata[LevelW-1:0];
    end
  end

  rsp929_seq #(
    .MAX_PARITY(MAX_PARITY)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(s_axis_tvalid_i),
    .cmd_i      (s_axis_tuser_i),
    .word_i     (s_axis_tdata_i[WordW-1:0]),
    .cmd_ready_o(s_axis_tready_o),
    .level_i    (level_q),
    .res_valid_o(seq_res_valid),
    .res_o      (seq_res),
    .res_ready_i(out_ready),
    .stat_o     (seq_stat)
  );

  // Output register: load when empty or draining
  assign out_ready = ~out_v_q | m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= seq_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && seq_res_valid) begin
      out_q <= seq_res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(16 - WordW){1'b0}}, out_q.parity_word};
  assign m_axis_tlast_o  = out_q.last;

  // Commands are only taken with the MAC pipeline empty
  a_ready_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !seq_stat.mac_busy)
    else $error("command taken while MAC pipeline still busy");

  // A parity word blocked by a full output register stays offered
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_res_valid && !out_ready) |=> seq_res_valid)
    else $error("parity word dropped while output register full");

  // No new command while a parity word waits for the output register
  a_busy_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_res_valid |-> !s_axis_tready_o)
    else $error("command ready while parity word pending");

  // Parity words are field elements
  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.parity_word < FieldP))
    else $error("parity word outside the field");

endmodule
